// ===== rtl/assert_macros.svh =====
// Assertion macros used by the deframer core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, ignored while reset is high.
`define VPD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: %m");
// Clocked property, also checked during reset.
`define VPD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed: %m");
`else
`define VPD_ASSERT(label, clk, rst, prop)
`define VPD_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/vpd_pkg.sv =====
// Types and constants of the video packet deframer.
// No dependencies; used by every file but assert_macros.svh through scoped names.
package vpd_pkg;

   localparam int unsigned HEADER_BYTES = 6;
   localparam int unsigned POS_W        = 24;
   localparam int unsigned PPF_W        = 9;

   localparam logic [PPF_W-1:0] PPF_RESET   = 9'd16;
   localparam logic [7:0]       FINAL_RESET = PPF_RESET[7:0] - 8'd1;

   // Header byte positions
   localparam logic [POS_W-1:0] POS_INDEX   = 24'd0;
   localparam logic [POS_W-1:0] POS_SUM_LO  = 24'd1;
   localparam logic [POS_W-1:0] POS_SUM_HI  = 24'd2;
   localparam logic [POS_W-1:0] POS_SIZE_LO = 24'd3;
   localparam logic [POS_W-1:0] POS_SIZE_MI = 24'd4;
   localparam logic [POS_W-1:0] POS_SIZE_HI = 24'd5;
   localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
   localparam logic [POS_W:0]   MIN_COUNT   = (POS_W+1)'(HEADER_BYTES);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       packet_end;
      logic       length_ok;
      logic       sum_ok;
      logic       sequence_ok;
      logic [7:0] packet_number;
      logic       frame_end;
      logic       frame_good;
   } rsp_item_type;

endpackage

// ===== rtl/vpd_if.sv =====
// Valid/ready channel interfaces for deframer items.
// Depends on vpd_pkg for the payload types.
interface vpd_req_if;
   logic                  valid;
   logic                  ready;
   vpd_pkg::req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface vpd_rsp_if;
   logic                  valid;
   logic                  ready;
   vpd_pkg::rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/vpd_in_stage.sv =====
// Input register of the deframer: holds one accepted item.
// Depends on vpd_pkg and vpd_req_if.
module vpd_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   vpd_req_if.sink               req_chan,
   input  logic                  drain,
   output logic                  s1_valid,
   output vpd_pkg::req_item_type s1_item
);
   logic                  s1_valid_ff, s1_valid_in;
   vpd_pkg::req_item_type s1_item_ff;
   logic                  accept;

   assign req_chan.ready = !s1_valid_ff || drain;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (drain) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_chan.payload;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;
endmodule

// ===== rtl/vpd_core.sv =====
// Header parser, running sum and sequence tracking of the deframer.
// Depends on vpd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vpd_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  vpd_pkg::req_item_type       item,
   input  logic [vpd_pkg::PPF_W-1:0]   packets_per_frame,
   output vpd_pkg::rsp_item_type       result
);
   logic [vpd_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                hdr_index_ff, hdr_index_in;
   logic [15:0]               hdr_sum_ff, hdr_sum_in;
   logic [23:0]               hdr_size_ff, hdr_size_in;
   logic [15:0]               run_sum_ff, run_sum_in;
   logic [7:0]                prev_index_ff, prev_index_in;
   logic                      intact_ff, intact_in;

   logic                      is_payload;
   logic [15:0]               sum_nx;
   logic [vpd_pkg::POS_W:0]   count;
   logic                      len_ok;
   logic [7:0]                final_idx;
   logic [7:0]                expect_idx;
   logic                      seq_ok;
   logic                      at_final;
   logic                      b_last;
   logic [7:0]                b;

   assign b      = item.data_byte;
   assign b_last = item.last_byte;

   // header capture, fields updated by the byte in hand are seen at once
   always_comb begin
      hdr_index_in = hdr_index_ff;
      hdr_sum_in   = hdr_sum_ff;
      hdr_size_in  = hdr_size_ff;
      is_payload   = 1'b0;
      case (pos_ff)
         vpd_pkg::POS_INDEX:   hdr_index_in       = b;
         vpd_pkg::POS_SUM_LO:  hdr_sum_in[7:0]    = b;
         vpd_pkg::POS_SUM_HI:  hdr_sum_in[15:8]   = b;
         vpd_pkg::POS_SIZE_LO: hdr_size_in[7:0]   = b;
         vpd_pkg::POS_SIZE_MI: hdr_size_in[15:8]  = b;
         vpd_pkg::POS_SIZE_HI: hdr_size_in[23:16] = b;
         default:              is_payload         = 1'b1;
      endcase
   end

   assign sum_nx     = is_payload ? run_sum_ff + {8'd0, b} : run_sum_ff;
   assign count      = {1'b0, pos_ff} + {{vpd_pkg::POS_W{1'b0}}, 1'b1};
   assign len_ok     = (count >= vpd_pkg::MIN_COUNT) && (count == {1'b0, hdr_size_in});
   assign final_idx  = packets_per_frame[7:0] - 8'd1;
   assign expect_idx = (hdr_index_in == 8'd0) ? final_idx : hdr_index_in - 8'd1;
   assign seq_ok     = (expect_idx == prev_index_ff);
   assign at_final   = (hdr_index_in == final_idx);

   always_comb begin
      result               = '0;
      result.payload_valid = is_payload;
      result.payload_byte  = is_payload ? b : 8'd0;
      if (b_last) begin
         result.packet_end    = 1'b1;
         result.length_ok     = len_ok;
         result.packet_number = hdr_index_in;
         if (len_ok) begin
            result.sum_ok      = (sum_nx == hdr_sum_in);
            result.sequence_ok = seq_ok;
            result.frame_end   = at_final;
            result.frame_good  = at_final && intact_ff && seq_ok;
         end
      end
   end

   always_comb begin
      pos_in        = pos_ff;
      run_sum_in    = sum_nx;
      prev_index_in = prev_index_ff;
      intact_in     = intact_ff;
      if (b_last) begin
         pos_in     = '0;
         run_sum_in = '0;
         if (len_ok) begin
            prev_index_in = hdr_index_in;
            intact_in     = at_final ? 1'b1 : (intact_ff && seq_ok);
         end
      end else if (pos_ff != vpd_pkg::POS_MAX) begin
         pos_in = pos_ff + {{(vpd_pkg::POS_W-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         hdr_index_ff  <= '0;
         hdr_sum_ff    <= '0;
         hdr_size_ff   <= '0;
         run_sum_ff    <= '0;
         prev_index_ff <= vpd_pkg::FINAL_RESET;
         intact_ff     <= 1'b1;
      end else if (advance) begin
         pos_ff        <= pos_in;
         hdr_index_ff  <= hdr_index_in;
         hdr_sum_ff    <= hdr_sum_in;
         hdr_size_ff   <= hdr_size_in;
         run_sum_ff    <= run_sum_in;
         prev_index_ff <= prev_index_in;
         intact_ff     <= intact_in;
      end
   end

   `VPD_ASSERT(a_pos_clear, clock, reset, (advance && b_last) |=> (pos_ff == '0))
   `VPD_ASSERT(a_pos_step, clock, reset, (advance && !b_last && pos_ff != vpd_pkg::POS_MAX)
      |=> (pos_ff == $past(pos_ff) + 24'd1))
   `VPD_ASSERT(a_frame_len, clock, reset, (advance && result.frame_end) |-> (result.length_ok && result.packet_end))
   `VPD_ASSERT(a_sum_clear, clock, reset, (advance && b_last) |=> (run_sum_ff == '0))
endmodule

// ===== rtl/vpd_out_stage.sv =====
// Result register of the deframer, drives the result channel.
// Depends on vpd_pkg and vpd_rsp_if.
module vpd_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  vpd_pkg::rsp_item_type item,
   output logic                  can_load,
   vpd_rsp_if.source             rsp_chan
);
   logic                  rsp_valid_ff, rsp_valid_in;
   vpd_pkg::rsp_item_type rsp_item_ff;

   assign can_load = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_item_ff <= item;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;
endmodule

// ===== rtl/video_packet_deframer.sv =====
// Video packet deframer: one datagram byte in, one tagged result out per item.
// Each item passes the input register, then the result register; header parse,
// sum and sequence check are one pass. 1 item per cycle while results are taken.
// Reset (synchronous, active high): empties both registers, clears the parser,
// sets packets_per_frame to 16 and the previous index to 15, frame intact.
// Depends on vpd_pkg, vpd_if, vpd_in_stage, vpd_core and vpd_out_stage.
module video_packet_deframer (
   input  logic                      clock,
   input  logic                      reset,
   vpd_req_if.sink                   req_chan,
   vpd_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [vpd_pkg::PPF_W-1:0] csr_wr_data
);
   // packets_per_frame register
   logic [vpd_pkg::PPF_W-1:0] csr_ppf_ff;

   logic                  s1_valid;
   vpd_pkg::req_item_type s1_item;
   vpd_pkg::rsp_item_type core_result;
   logic                  can_load;
   logic                  advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ppf_ff <= vpd_pkg::PPF_RESET;
      end else if (csr_wr_en) begin
         csr_ppf_ff <= csr_wr_data;
      end
   end

   // The held item moves on, and the parser state steps, whenever the
   // result register is free or being emptied this cycle.
   assign advance = s1_valid && can_load;

   vpd_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .drain    (advance),
      .s1_valid (s1_valid),
      .s1_item  (s1_item)
   );

   vpd_core u_core (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .item              (s1_item),
      .packets_per_frame (csr_ppf_ff),
      .result            (core_result)
   );

   vpd_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .item     (core_result),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );
endmodule

// ===== test/video_packet_deframer_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for video_packet_deframer: datagram bytes in, tagged results out.
// Depends on vpd_pkg, vpd_if and the deframer RTL; holds its own model of the parser.

typedef logic [7:0] byte_list_type[$];

// Tracks the parser state of the block and queues the result each byte should give.
class deframe_tracker_type;
   logic [8:0]            frame_size;
   logic [23:0]           position;
   logic [7:0]            hdr_index;
   logic [15:0]           hdr_sum;
   logic [23:0]           hdr_size;
   logic [15:0]           payload_sum;
   logic [7:0]            last_index;
   bit                    frame_intact;
   vpd_pkg::rsp_item_type pending_results[$];
   int                    errors;
   int                    checked;
   int                    frame_ends;

   function new();
      frame_size   = vpd_pkg::PPF_RESET;
      position     = '0;
      hdr_index    = '0;
      hdr_sum      = '0;
      hdr_size     = '0;
      payload_sum  = '0;
      last_index   = vpd_pkg::FINAL_RESET;
      frame_intact = 1'b1;
      errors       = 0;
      checked      = 0;
      frame_ends   = 0;
   endfunction

   function logic [7:0] final_index();
      logic [8:0] m;
      m = frame_size - 9'd1;
      return m[7:0];
   endfunction

   function void set_frame_size(logic [8:0] value);
      frame_size = value;
   endfunction

   function int pending();
      return pending_results.size();
   endfunction

   // Work out the result of one accepted byte and advance the parser.
   function void note_byte(vpd_pkg::req_item_type item);
      vpd_pkg::rsp_item_type r;
      logic [24:0]           count;
      logic [7:0]            prior;
      bit                    in_seq;
      r = '0;
      case (position)
         vpd_pkg::POS_INDEX:   hdr_index      = item.data_byte;
         vpd_pkg::POS_SUM_LO:  hdr_sum[7:0]   = item.data_byte;
         vpd_pkg::POS_SUM_HI:  hdr_sum[15:8]  = item.data_byte;
         vpd_pkg::POS_SIZE_LO: hdr_size[7:0]  = item.data_byte;
         vpd_pkg::POS_SIZE_MI: hdr_size[15:8] = item.data_byte;
         vpd_pkg::POS_SIZE_HI: hdr_size[23:16] = item.data_byte;
         default: begin
            r.payload_valid = 1'b1;
            r.payload_byte  = item.data_byte;
            payload_sum     = payload_sum + 16'(item.data_byte);
         end
      endcase
      if (item.last_byte) begin
         count           = {1'b0, position} + 25'd1;
         r.packet_end    = 1'b1;
         r.packet_number = hdr_index;
         r.length_ok     = (count >= vpd_pkg::MIN_COUNT) && (count == {1'b0, hdr_size});
         if (r.length_ok) begin
            prior         = (hdr_index == 8'd0) ? final_index() : hdr_index - 8'd1;
            in_seq        = (prior == last_index);
            r.sum_ok      = (payload_sum == hdr_sum);
            r.sequence_ok = in_seq;
            if (!in_seq) frame_intact = 1'b0;
            last_index = hdr_index;
            if (hdr_index == final_index()) begin
               r.frame_end  = 1'b1;
               r.frame_good = frame_intact;
               frame_intact = 1'b1;
               frame_ends++;
            end
         end
         position    = '0;
         payload_sum = '0;
      end else if (position != vpd_pkg::POS_MAX) begin
         position = position + 24'd1;
      end
      pending_results = {pending_results, r};
   endfunction

   task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got, want));
   endtask

   task check_result(vpd_pkg::rsp_item_type got);
      vpd_pkg::rsp_item_type want;
      if (pending_results.size() == 0) begin
         report("result arrived with nothing outstanding");
      end else begin
         want = pending_results.pop_front();
         check_field("payload_valid", got.payload_valid, want.payload_valid);
         check_field("payload_byte", got.payload_byte, want.payload_byte);
         check_field("packet_end", got.packet_end, want.packet_end);
         check_field("length_ok", got.length_ok, want.length_ok);
         check_field("sum_ok", got.sum_ok, want.sum_ok);
         check_field("sequence_ok", got.sequence_ok, want.sequence_ok);
         check_field("packet_number", got.packet_number, want.packet_number);
         check_field("frame_end", got.frame_end, want.frame_end);
         check_field("frame_good", got.frame_good, want.frame_good);
      end
      checked++;
   endtask
endclass

module video_packet_deframer_test;

   // Cycles without any handshake before the run is declared hung.  Idle gaps
   // are geometric at 23 %, none in the third random phase.
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1450;
   localparam int TAIL_CYCLES  = 4;   // a little over the two-stage latency

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_wr_en;
   logic [vpd_pkg::PPF_W-1:0] csr_wr_data;

   vpd_req_if req_bus ();
   vpd_rsp_if rsp_bus ();

   deframe_tracker_type track;

   int idle_pct = 23;    // chance, in percent, that either side idles in a cycle
   int quiet_cycles = 0;
   int bytes_sent = 0;
   int datagrams_sent = 0;
   int sizes_used = 1;   // reset value counts as the first setting

   video_packet_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Result side: ready is redrawn at every falling edge.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
   end

   // Results are taken at the rising edge and checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) track.check_result(rsp_bus.payload);
   end

   // Watchdog: any handshake on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("video_packet_deframer_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one byte; called and returns at a falling edge.  Valid is only
   // dropped when an idle gap is taken, so back-to-back items keep it high.
   task automatic send_byte(input logic [7:0] data, input logic last);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(0, 99) < idle_pct) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= '{data_byte: data, last_byte: last};
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      track.note_byte(req_bus.payload);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_datagram(input byte_list_type dg);
      for (int i = 0; i < dg.size(); i++) send_byte(dg[i], i == dg.size() - 1);
      datagrams_sent++;
   endtask

   // Stop offering items and wait until every expected result is out.
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (track.pending() != 0);
   endtask

   // Register write, only with the block empty.
   task automatic write_frame_size(input logic [8:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      track.set_frame_size(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sizes_used++;
   endtask

   function automatic byte_list_type random_bytes(input int n);
      byte_list_type dg;
      for (int i = 0; i < n; i++) dg = {dg, 8'($urandom)};
      return dg;
   endfunction

   // Header plus random payload; the sum and size can be spoilt on request.
   function automatic byte_list_type build_packet(input logic [7:0] idx, input int len,
                                                  input bit bad_sum, input bit bad_size);
      byte_list_type dg;
      logic [15:0]   sum;
      logic [23:0]   size;
      logic [23:0]   true_size;
      logic [7:0]    b;
      sum = '0;
      dg  = '{idx, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         dg = {dg, b};
         sum = sum + 16'(b);
      end
      true_size = 24'(vpd_pkg::HEADER_BYTES + len);
      size      = true_size;
      if (bad_sum) sum = sum + 16'($urandom_range(1, 65535));
      if (bad_size) begin
         size = $urandom_range(0, 1) ? true_size + 24'($urandom_range(1, 4)) : 24'($urandom);
         if (size == true_size) size = size ^ 24'h1;
      end
      dg[1] = sum[7:0];
      dg[2] = sum[15:8];
      dg[3] = size[7:0];
      dg[4] = size[15:8];
      dg[5] = size[23:16];
      return dg;
   endfunction

   // Mostly well-formed packets following the last accepted index; the rest
   // have a bad sum or size, are cut short inside the header, or are noise.
   task automatic send_random_datagram(input bit jump);
      byte_list_type dg;
      logic [7:0]    idx;
      logic [7:0]    fin;
      int            kind;
      int            len;
      fin = track.final_index();
      idx = (track.last_index >= fin) ? 8'd0 : track.last_index + 8'd1;
      if (jump) idx = fin - 8'($urandom_range(0, 3));
      else if ($urandom_range(0, 9) == 0) idx = 8'($urandom);
      len  = ($urandom_range(0, 29) == 0) ? $urandom_range(17, 300) : $urandom_range(0, 16);
      kind = $urandom_range(0, 99);
      if (kind < 75)      dg = build_packet(idx, len, $urandom_range(0, 9) == 0, 1'b0);
      else if (kind < 85) dg = build_packet(idx, len, $urandom_range(0, 1), 1'b1);
      else if (kind < 93) dg = random_bytes($urandom_range(1, 5));
      else                dg = random_bytes($urandom_range(1, 30));
      send_datagram(dg);
   endtask

   initial begin
      int         frame_sizes[$];
      int         phase_start;
      int         per_phase;
      track = new();
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = vpd_pkg::PPF_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items at the reset frame size of 16.
      // Lone byte: short datagram, index reported from that byte.
      send_datagram('{8'h00});
      // Short datagram ending inside the sum field.
      send_datagram('{8'hAB, 8'hCD, 8'hEF});
      // Index 0 after the reset previous index 15: in sequence, payload FF 00, sum 00FF.
      send_datagram('{8'h00, 8'hFF, 8'h00, 8'h08, 8'h00, 8'h00, 8'hFF, 8'h00});
      // Header-only datagram claiming the largest size: length failure.
      send_datagram('{8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});

      // Random phases, one per frame size: one packet per frame, the widest
      // setting, a small one, zero and oversized values, and a random one.
      frame_sizes = '{1, 256, 4, 0, 300};
      frame_sizes = {frame_sizes, int'($urandom_range(2, 255))};
      per_phase = RANDOM_ITEMS / frame_sizes.size();
      foreach (frame_sizes[p]) begin
         write_frame_size(9'(frame_sizes[p]));
         // third phase runs with both sides flat out
         idle_pct    = (p == 2) ? 0 : 23;
         phase_start = bytes_sent;
         // open each phase near the last index so frame ends come soon
         send_random_datagram(1'b1);
         while (bytes_sent - phase_start < per_phase) send_random_datagram(1'b0);
      end
      idle_pct = 23;

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (track.pending() != 0) track.report("expected results left over at the end");

      $display("covered %0d bytes in %0d datagrams over %0d frame-size settings",
               bytes_sent, datagrams_sent, sizes_used);
      $display("checked %0d results, %0d of them frame ends; %0d mismatches",
               track.checked, track.frame_ends, track.errors);
      if (track.errors == 0) begin
         $display("video_packet_deframer_test: done, clean");
      end else begin
         $display("video_packet_deframer_test: done, errors");
      end
      $finish;
   end

endmodule
